@@ rtl/spq_pkg.sv @@
// Shared constants, codes, types and key ordering for the sorted priority queue.
package spq_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int COUNT_W     = $clog2(CAPACITY + 1);
  localparam int REQ_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int ELEM_W      = 32;
  localparam int HEAD_W      = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 1;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_PEEK   = 2'd1,
    REQ_POP    = 2'd2
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORDER_DESC  = 1'd0,
    CFG_SIGNED_KEYS = 1'd1
  } cfg_idx_t;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  typedef struct packed {
    logic   ins;
    logic   pop;
    value_t val;
    logic   desc;
    logic   sgn;
  } cell_ctrl_t;

  function automatic value_t order_key(value_t v, logic desc, logic sgn);
    value_t k;
    k = v;
    if (sgn) k[VALUE_WIDTH-1] = ~k[VALUE_WIDTH-1];
    if (desc) k = ~k;
    return k;
  endfunction

endpackage

@@ rtl/spq_if.sv @@
// Request and result channel interfaces of the sorted priority queue.
interface spq_req_if;
  logic                         valid;
  logic                         ready;
  logic [spq_pkg::REQ_W-1:0]    req_type;
  logic [spq_pkg::ELEM_W-1:0]   elem_value;

  modport source (output valid, req_type, elem_value, input ready);
  modport sink   (input valid, req_type, elem_value, output ready);
endinterface

interface spq_res_if;
  logic                          valid;
  logic                          ready;
  logic [spq_pkg::STATUS_W-1:0]  status;
  logic [spq_pkg::HEAD_W-1:0]    head_value;
  logic [spq_pkg::COUNT_W-1:0]   entry_count;

  modport source (output valid, status, head_value, entry_count, input ready);
  modport sink   (input valid, status, head_value, entry_count, output ready);
endinterface

@@ rtl/spq_cell.sv @@
// One slot of the sorted chain: compare against the new value and shift.
module spq_cell (
  input  logic                  clk,
  input  spq_pkg::cell_ctrl_t   ctrl,
  input  logic                  occupied,
  input  logic                  left_take,
  input  spq_pkg::value_t       left_value,
  input  spq_pkg::value_t       right_value,
  output logic                  take,
  output spq_pkg::value_t       value
);

  spq_pkg::value_t value_r;
  spq_pkg::value_t value_nxt;
  logic            goes_first;

  assign goes_first = spq_pkg::order_key(ctrl.val, ctrl.desc, ctrl.sgn)
                      <= spq_pkg::order_key(value_r, ctrl.desc, ctrl.sgn);
  // once a cell toward the head takes the new value, every later cell shifts
  assign take       = left_take || goes_first || !occupied;
  assign value      = value_r;

  always_comb begin
    value_nxt = value_r;
    if (ctrl.ins && take) begin
      value_nxt = left_take ? left_value : ctrl.val;
    end else if (ctrl.pop) begin
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

@@ rtl/sorted_priority_queue_core.sv @@
// Sorted priority queue: a chain of CAPACITY cells kept in service order, head
// in cell 0. On each request every cell compares the new value with its own
// entry and shifts toward the tail on insert, or toward the head on pop, in the
// same clock. Results sit in an output register, so a new request is taken every
// cycle while the result side keeps up, and none while a result waits unread.
// Insert into a full queue returns full; peek or pop on an empty queue returns
// empty. The user must set order and signedness through the configuration port
// only while no request is in flight; the core does not enforce this.
module sorted_priority_queue_core (
  input  logic                           clk,
  input  logic                           rst_n,
  spq_req_if.sink                        in_req,
  spq_res_if.source                      out_res,
  input  logic                           cfg_we,
  input  logic [spq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spq_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic                         desc_r;
  logic                         sgn_r;
  logic [spq_pkg::COUNT_W-1:0]  count_r;
  logic [spq_pkg::COUNT_W-1:0]  count_nxt;
  logic                         out_valid_r;
  spq_pkg::status_t             status_r;
  spq_pkg::status_t             status_nxt;
  logic [spq_pkg::HEAD_W-1:0]   head_r;
  logic [spq_pkg::HEAD_W-1:0]   head_nxt;

  logic                         accept;
  logic                         full;
  logic                         empty;
  spq_pkg::cell_ctrl_t          ctrl;
  spq_pkg::value_t              cell_value [spq_pkg::CAPACITY];
  logic                         cell_take  [spq_pkg::CAPACITY];

  assign in_req.ready = !out_valid_r || out_res.ready;
  assign accept       = in_req.valid && in_req.ready;
  assign full         = count_r == spq_pkg::COUNT_W'(spq_pkg::CAPACITY);
  assign empty        = count_r == '0;

  always_comb begin
    ctrl.ins   = 1'b0;
    ctrl.pop   = 1'b0;
    ctrl.val   = spq_pkg::VALUE_WIDTH'(in_req.elem_value);
    ctrl.desc  = desc_r;
    ctrl.sgn   = sgn_r;
    count_nxt  = count_r;
    status_nxt = spq_pkg::ST_DONE;
    head_nxt   = '0;
    case (in_req.req_type)
      spq_pkg::REQ_INSERT: begin
        if (full) begin
          status_nxt = spq_pkg::ST_FULL;
        end else begin
          ctrl.ins  = accept;
          count_nxt = count_r + 1'b1;
        end
      end
      spq_pkg::REQ_PEEK, spq_pkg::REQ_POP: begin
        if (empty) begin
          status_nxt = spq_pkg::ST_EMPTY;
        end else begin
          head_nxt = spq_pkg::HEAD_W'(cell_value[0]);
          if (in_req.req_type == spq_pkg::REQ_POP) begin
            ctrl.pop  = accept;
            count_nxt = count_r - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  for (genvar i = 0; i < spq_pkg::CAPACITY; i++) begin : g_cell
    logic            left_take;
    spq_pkg::value_t left_value;
    spq_pkg::value_t right_value;

    if (i == 0) begin : g_head
      assign left_take  = 1'b0;
      assign left_value = ctrl.val;
    end else begin : g_mid
      assign left_take  = cell_take[i-1];
      assign left_value = cell_value[i-1];
    end

    if (i == spq_pkg::CAPACITY - 1) begin : g_tail
      assign right_value = cell_value[i];
    end else begin : g_body
      assign right_value = cell_value[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (spq_pkg::COUNT_W'(i) < count_r),
      .left_take   (left_take),
      .left_value  (left_value),
      .right_value (right_value),
      .take        (cell_take[i]),
      .value       (cell_value[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r      <= 1'b0;
      sgn_r       <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          spq_pkg::CFG_ORDER_DESC:  desc_r <= cfg_wdata[0];
          spq_pkg::CFG_SIGNED_KEYS: sgn_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      head_r   <= head_nxt;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.status      = status_r;
  assign out_res.head_value  = head_r;
  assign out_res.entry_count = count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= spq_pkg::COUNT_W'(spq_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_req.req_type == spq_pkg::REQ_INSERT && full
    |=> out_res.valid && out_res.status == spq_pkg::ST_FULL && $stable(count_r))
    else $error("insert into full queue not refused");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_req.req_type == spq_pkg::REQ_POP && !empty
    |=> count_r == $past(count_r) - 1'b1)
    else $error("pop did not remove an entry");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.status == spq_pkg::ST_EMPTY
    |-> out_res.head_value == '0 && out_res.entry_count == '0)
    else $error("empty result carries data");

endmodule

@@ bench/sorted_priority_queue_core_test.sv @@
// Self-checking testbench for the sorted priority queue core.
`timescale 1ns / 100ps

module sorted_priority_queue_core_test;

  localparam logic [spq_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 115;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    spq_pkg::status_t                 status;
    logic [spq_pkg::HEAD_W-1:0]       head;
    logic [spq_pkg::COUNT_W-1:0]      count;
  } outcome_t;

  class queue_scoreboard;
    spq_pkg::value_t entries[spq_pkg::CAPACITY];
    int unsigned     fill = 0;
    bit              descending = 1'b0;
    bit              signed_cmp = 1'b0;
    outcome_t        expected[$];
    int              errors = 0;

    function void set_register(spq_pkg::cfg_idx_t idx, logic bit_val);
      if (idx == spq_pkg::CFG_ORDER_DESC) begin
        descending = bit_val;
      end else begin
        signed_cmp = bit_val;
      end
    endfunction

    function bit precedes(spq_pkg::value_t a, spq_pkg::value_t b);
      if (signed_cmp) begin
        return descending ? ($signed(a) >= $signed(b)) : ($signed(a) <= $signed(b));
      end
      return descending ? (a >= b) : (a <= b);
    endfunction

    function void note_request(logic [spq_pkg::REQ_W-1:0] kind,
                               logic [spq_pkg::ELEM_W-1:0] v);
      outcome_t    o;
      int unsigned pos;
      o.status = spq_pkg::ST_DONE;
      o.head = '0;
      case (kind)
        spq_pkg::REQ_INSERT: begin
          if (fill >= spq_pkg::CAPACITY) begin
            o.status = spq_pkg::ST_FULL;
          end else begin
            pos = fill;
            for (int i = 0; i < fill; i++) begin
              if (precedes(v, entries[i])) begin
                pos = i;
                break;
              end
            end
            for (int i = fill; i > pos; i--) entries[i] = entries[i-1];
            entries[pos] = v;
            fill++;
          end
        end
        spq_pkg::REQ_PEEK, spq_pkg::REQ_POP: begin
          if (fill == 0) begin
            o.status = spq_pkg::ST_EMPTY;
          end else begin
            o.head = entries[0];
            if (kind == spq_pkg::REQ_POP) begin
              for (int i = 0; i + 1 < fill; i++) entries[i] = entries[i+1];
              fill--;
            end
          end
        end
        default: ;
      endcase
      o.count = spq_pkg::COUNT_W'(fill);
      expected.push_back(o);
    endfunction

    function void check_result(logic [spq_pkg::STATUS_W-1:0] st,
                               logic [spq_pkg::HEAD_W-1:0] hd,
                               logic [spq_pkg::COUNT_W-1:0] cnt);
      outcome_t o;
      if (expected.size() == 0) begin
        $error("result with no request pending: status %0d head %h count %0d",
               st, hd, cnt);
        errors++;
        return;
      end
      o = expected.pop_front();
      if (st !== o.status) begin
        $error("status: expected %0d, actual %0d", o.status, st);
        errors++;
      end
      if (hd !== o.head) begin
        $error("head_value: expected %h, actual %h", o.head, hd);
        errors++;
      end
      if (cnt !== o.count) begin
        $error("entry_count: expected %0d, actual %0d", o.count, cnt);
        errors++;
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [spq_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [spq_pkg::CFG_DATA_W-1:0] cfg_wdata;
  bit                             steady = 1'b0;
  int unsigned                    cycles = 0;
  queue_scoreboard                sb = new;

  spq_req_if in_req();
  spq_res_if out_res();

  sorted_priority_queue_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_res.ready <= 1'b0;
    end else begin
      out_res.ready <= steady || ($urandom_range(99) >= 13);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_res.valid && out_res.ready) begin
        sb.check_result(out_res.status, out_res.head_value, out_res.entry_count);
      end
      if (in_req.valid && in_req.ready) begin
        sb.note_request(in_req.req_type, in_req.elem_value);
      end
    end
  end

  task automatic send_request(input logic [spq_pkg::REQ_W-1:0] kind,
                              input logic [spq_pkg::ELEM_W-1:0] v);
    if (!steady && $urandom_range(99) < 13) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_req.valid      <= 1'b1;
    in_req.req_type   <= kind;
    in_req.elem_value <= v;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
  endtask

  task automatic settle();
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_config(input logic desc, input logic sgn);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= spq_pkg::CFG_ORDER_DESC;
    cfg_wdata <= desc;
    @(posedge clk);
    cfg_index <= spq_pkg::CFG_SIGNED_KEYS;
    cfg_wdata <= sgn;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(spq_pkg::CFG_ORDER_DESC, desc);
    sb.set_register(spq_pkg::CFG_SIGNED_KEYS, sgn);
  endtask

  function automatic logic [spq_pkg::ELEM_W-1:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom();
      4, 5:       return $urandom_range(0, 7);
      6:          return 32'h7FFF_FFFC + $urandom_range(0, 7);
      7:          return 32'hFFFF_FFF8 + $urandom_range(0, 7);
      default:    return {2'($urandom_range(0, 3)), 30'h0} | 32'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [spq_pkg::REQ_W-1:0] pick_kind(int insert_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3) return REQ_UNUSED;
    if (roll < 3 + insert_pct * 97 / 100) return spq_pkg::REQ_INSERT;
    return ($urandom_range(2) == 0) ? spq_pkg::REQ_PEEK : spq_pkg::REQ_POP;
  endfunction

  initial begin
    int insert_pct;
    logic desc, sgn;
    rst_n             <= 1'b0;
    in_req.valid      <= 1'b0;
    in_req.req_type   <= spq_pkg::REQ_INSERT;
    in_req.elem_value <= '0;
    cfg_we            <= 1'b0;
    cfg_index         <= spq_pkg::CFG_ORDER_DESC;
    cfg_wdata         <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(spq_pkg::REQ_PEEK, '0);
    send_request(spq_pkg::REQ_POP, '0);
    send_request(REQ_UNUSED, 32'hFFFF_FFFF);
    send_request(spq_pkg::REQ_INSERT, 32'h0000_0000);
    send_request(spq_pkg::REQ_INSERT, 32'hFFFF_FFFF);
    send_request(spq_pkg::REQ_INSERT, 32'h8000_0000);
    send_request(spq_pkg::REQ_INSERT, 32'h7FFF_FFFF);
    send_request(spq_pkg::REQ_PEEK, 32'h1234_5678);
    send_request(REQ_UNUSED, '0);
    send_request(spq_pkg::REQ_POP, '0);
    for (int i = 0; i < 13; i++) begin
      send_request(spq_pkg::REQ_INSERT, (i % 3 == 0) ? 32'h5 : $urandom());
    end
    send_request(spq_pkg::REQ_INSERT, 32'hA5A5_5A5A);
    send_request(spq_pkg::REQ_POP, '0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 4) begin
        desc = p[0];
        sgn  = p[1];
      end else begin
        desc = 1'($urandom_range(1));
        sgn  = 1'($urandom_range(1));
      end
      set_config(desc, sgn);
      steady = (p == 4);
      case (p % 3)
        0:       insert_pct = 50;
        1:       insert_pct = 75;
        default: insert_pct = 30;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_request(pick_kind(insert_pct), pick_value());
      end
    end
    steady = 1'b0;

    settle();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
